/* hw/rtl/ntcc_pkg.sv */
package ntcc_pkg;

    localparam int CHAN_W = 4;
    localparam int CODE_W = 16;
    localparam int RES_W  = 20;
    localparam int RT_W   = 28;
    localparam int TEMP_W = 15;

    localparam logic [RES_W-1:0] DIV_RES_RESET = 20'd10000;
    localparam logic [RT_W-1:0]  RT_MAX        = 28'hFFFFFFF;

    // extended steinhart-hart coefficients, q.40
    localparam logic signed [17:0] COEF_D = 18'sd69591;
    localparam logic signed [23:0] COEF_C = 24'sd2865294;
    localparam logic signed [30:0] COEF_B = 31'sd282050681;
    localparam logic signed [37:0] COEF_A = 38'sd3687780071;

    localparam logic [29:0]        LN2_Q30     = 30'd744261118;
    localparam logic signed [25:0] LN_RT_SCALE = 26'sd15472282;
    localparam logic [47:0]        KELVIN_NUM  = 48'h640000000000;   // 100 << 40
    localparam logic signed [16:0] KELVIN_OFS  = 17'sd27315;
    localparam logic signed [16:0] T_HIGH      = 17'sd15000;
    localparam logic signed [16:0] T_LOW       = -17'sd4000;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_SAT     = 2'd2
    } status_t;

    // control that travels beside each pipeline stage
    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] channel;
        logic              bad;
    } ctl_t;

endpackage

/* hw/rtl/ntcc_ratio.sv */
module ntcc_ratio
    import ntcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  ctl_t              in_ctl,
    input  logic [CODE_W-1:0] reading,
    input  logic [CODE_W-1:0] reference,
    input  logic [RES_W-1:0]  div_res,
    output ctl_t              out_ctl,
    output logic [RT_W-1:0]   rt_quot,
    output logic              rt_ovf
);

    // ratio divider: 16 restoring steps
    ctl_t        c1_reg   [0:16];
    logic [15:0] rem1_reg [0:16];
    logic [15:0] den1_reg [0:16];
    logic [15:0] q1_reg   [0:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg[0] <= '0;
        end
        else if (en)
        begin
            c1_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem1_reg[0] <= reading;
            den1_reg[0] <= reference;
            q1_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < 16; k++)
    begin : g_ratio
        logic [16:0] t;
        logic        ge;
        assign t  = {rem1_reg[k], 1'b0};
        assign ge = t >= {1'b0, den1_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c1_reg[k+1] <= '0;
            end
            else if (en)
            begin
                c1_reg[k+1] <= c1_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem1_reg[k+1] <= ge ? 16'(t - {1'b0, den1_reg[k]}) : t[15:0];
                den1_reg[k+1] <= den1_reg[k];
                q1_reg[k+1]   <= {q1_reg[k][14:0], ge};
            end
        end
    end

    // numerator product and 65536 - ratio
    ctl_t        cm_reg;
    logic [35:0] prod_reg;
    logic [16:0] denm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cm_reg <= '0;
        end
        else if (en)
        begin
            cm_reg <= c1_reg[16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 36'(q1_reg[16]) * 36'(div_res);
            denm_reg <= 17'h10000 - {1'b0, q1_reg[16]};
        end
    end

    // resistance divider: overflow check then 28 restoring steps
    ctl_t        c2_reg   [0:28];
    logic [16:0] rem2_reg [0:28];
    logic [16:0] den2_reg [0:28];
    logic [27:0] low2_reg [0:28];
    logic [27:0] q2_reg   [0:28];
    logic        ovf2_reg [0:28];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg[0] <= '0;
        end
        else if (en)
        begin
            c2_reg[0] <= cm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem2_reg[0] <= {1'b0, prod_reg[35:20]};
            den2_reg[0] <= denm_reg;
            low2_reg[0] <= {prod_reg[19:0], 8'h00};
            q2_reg[0]   <= '0;
            ovf2_reg[0] <= {1'b0, prod_reg[35:20]} >= denm_reg;
        end
    end

    for (genvar k = 0; k < 28; k++)
    begin : g_rt
        logic [17:0] t;
        logic        ge;
        assign t  = {rem2_reg[k], low2_reg[k][27-k]};
        assign ge = t >= {1'b0, den2_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c2_reg[k+1] <= '0;
            end
            else if (en)
            begin
                c2_reg[k+1] <= c2_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem2_reg[k+1] <= ge ? 17'(t - {1'b0, den2_reg[k]}) : t[16:0];
                den2_reg[k+1] <= den2_reg[k];
                low2_reg[k+1] <= low2_reg[k];
                q2_reg[k+1]   <= {q2_reg[k][26:0], ge};
                ovf2_reg[k+1] <= ovf2_reg[k];
            end
        end
    end

    assign out_ctl = c2_reg[28];
    assign rt_quot = q2_reg[28];
    assign rt_ovf  = ovf2_reg[28];

endmodule

/* hw/rtl/ntcc_log.sv */
module ntcc_log
    import ntcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  ctl_t               in_ctl,
    input  logic [RT_W-1:0]    rt_quot,
    input  logic               rt_ovf,
    output ctl_t               out_ctl,
    output logic signed [25:0] ln_val
);

    // clamp
    ctl_t            ca_reg;
    logic [RT_W-1:0] rta_reg;

    // leading one
    ctl_t            cb_reg;
    logic [RT_W-1:0] rtb_reg;
    logic [4:0]      eb_reg;
    logic [4:0]      e_next;

    always_comb
    begin
        e_next = '0;
        for (int i = 0; i < RT_W; i++)
        begin
            if (rta_reg[i])
            begin
                e_next = 5'(i);
            end
        end
    end

    // squaring chain
    ctl_t        cs_reg [0:20];
    logic [30:0] m_reg  [0:20];
    logic [4:0]  e_reg  [0:20];
    logic [19:0] f_reg  [0:20];

    // ln scaling
    ctl_t        cp_reg;
    logic [54:0] lp_reg;
    ctl_t        cl_reg;
    logic signed [25:0] l_reg;
    logic [54:0] lr;

    assign lr = lp_reg + (55'd1 << 29);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg    <= '0;
            cb_reg    <= '0;
            cs_reg[0] <= '0;
            cp_reg    <= '0;
            cl_reg    <= '0;
        end
        else if (en)
        begin
            ca_reg    <= in_ctl;
            cb_reg    <= ca_reg;
            cs_reg[0] <= cb_reg;
            cp_reg    <= cs_reg[20];
            cl_reg    <= cp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rta_reg  <= rt_ovf ? RT_MAX : ((rt_quot == '0) ? RT_W'(1) : rt_quot);
            rtb_reg  <= rta_reg;
            eb_reg   <= e_next;
            m_reg[0] <= 31'({3'b000, rtb_reg} << (5'd30 - eb_reg));
            e_reg[0] <= eb_reg;
            f_reg[0] <= '0;
            lp_reg   <= 55'({e_reg[20], f_reg[20]}) * 55'(LN2_Q30);
            l_reg    <= $signed({1'b0, lr[54:30]}) - LN_RT_SCALE;
        end
    end

    for (genvar k = 0; k < 20; k++)
    begin : g_sq
        logic [61:0] sq;
        logic        hi;
        assign sq = 62'(m_reg[k]) * 62'(m_reg[k]);
        assign hi = sq[61];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cs_reg[k+1] <= '0;
            end
            else if (en)
            begin
                cs_reg[k+1] <= cs_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[k+1] <= hi ? sq[61:31] : sq[60:30];
                e_reg[k+1] <= e_reg[k];
                f_reg[k+1] <= {f_reg[k][18:0], hi};
            end
        end
    end

    assign out_ctl = cl_reg;
    assign ln_val  = l_reg;

endmodule

/* hw/rtl/ntcc_poly.sv */
module ntcc_poly
    import ntcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  ctl_t               in_ctl,
    input  logic signed [25:0] ln_val,
    output ctl_t               out_ctl,
    output logic [TEMP_W-1:0]  temperature,
    output status_t            status
);

    // horner evaluation, one multiply or one add per stage
    ctl_t c_reg [0:5];
    logic signed [25:0] l_reg [0:5];
    logic signed [43:0] p1_reg;
    logic signed [23:0] s1_reg;
    logic signed [49:0] p2_reg;
    logic signed [30:0] s2_reg;
    logic signed [56:0] p3_reg;
    logic signed [37:0] s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg[0] <= '0;
        end
        else if (en)
        begin
            c_reg[0] <= in_ctl;
        end
    end

    for (genvar k = 0; k < 5; k++)
    begin : g_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_reg[k+1] <= '0;
            end
            else if (en)
            begin
                c_reg[k+1] <= c_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                l_reg[k+1] <= l_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg[0] <= ln_val;
            p1_reg   <= 44'(ln_val) * 44'(COEF_D);
            s1_reg   <= 24'(p1_reg >>> 20) + COEF_C;
            p2_reg   <= 50'(s1_reg) * 50'(l_reg[1]);
            s2_reg   <= 31'(p2_reg >>> 20) + COEF_B;
            p3_reg   <= 57'(s2_reg) * 57'(l_reg[3]);
            s_reg    <= 38'(p3_reg >>> 20) + COEF_A;
        end
    end

    // reciprocal: overflow check then 16 restoring steps
    logic        nonpos;
    logic [36:0] sd;
    logic [47:0] num;
    assign nonpos = s_reg[37] || (s_reg == '0);
    assign sd     = s_reg[36:0];
    assign num    = KELVIN_NUM + 48'(sd >> 1);

    ctl_t        cd_reg  [0:16];
    logic [36:0] rem_reg [0:16];
    logic [36:0] den_reg [0:16];
    logic [15:0] low_reg [0:16];
    logic [15:0] q_reg   [0:16];
    logic        sat_reg [0:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg[0] <= '0;
        end
        else if (en)
        begin
            cd_reg[0] <= c_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {5'b00000, num[47:16]};
            den_reg[0] <= sd;
            low_reg[0] <= num[15:0];
            q_reg[0]   <= '0;
            sat_reg[0] <= nonpos || ({5'b00000, num} >= {sd, 16'h0000});
        end
    end

    for (genvar k = 0; k < 16; k++)
    begin : g_rcp
        logic [37:0] t;
        logic        ge;
        assign t  = {rem_reg[k], low_reg[k][15-k]};
        assign ge = t >= {1'b0, den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_reg[k+1] <= '0;
            end
            else if (en)
            begin
                cd_reg[k+1] <= cd_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? 37'(t - {1'b0, den_reg[k]}) : t[36:0];
                den_reg[k+1] <= den_reg[k];
                low_reg[k+1] <= low_reg[k];
                q_reg[k+1]   <= {q_reg[k][14:0], ge};
                sat_reg[k+1] <= sat_reg[k];
            end
        end
    end

    // kelvin to celsius and limits
    logic signed [16:0] tk;
    logic [TEMP_W-1:0]  temp_next;
    status_t            status_next;
    ctl_t               co_reg;
    logic [TEMP_W-1:0]  temp_reg;
    status_t            status_reg;

    assign tk = $signed({1'b0, q_reg[16]}) - KELVIN_OFS;

    always_comb
    begin
        temp_next   = TEMP_W'(tk);
        status_next = STATUS_OK;
        if (cd_reg[16].bad)
        begin
            temp_next   = '0;
            status_next = STATUS_INVALID;
        end
        else if (sat_reg[16] || (tk > T_HIGH))
        begin
            temp_next   = TEMP_W'(T_HIGH);
            status_next = STATUS_SAT;
        end
        else if (tk < T_LOW)
        begin
            temp_next   = TEMP_W'(T_LOW);
            status_next = STATUS_SAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            co_reg <= '0;
        end
        else if (en)
        begin
            co_reg <= cd_reg[16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg   <= temp_next;
            status_reg <= status_next;
        end
    end

    assign out_ctl     = co_reg;
    assign temperature = temp_reg;
    assign status      = status_reg;

endmodule

/* hw/rtl/ntcc_outq.sv */
module ntcc_outq #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         space,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic [1:0]   count_reg;
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [W-1:0] slot_reg [0:1];
    logic         pop;

    assign space     = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/thermistor_voltage_to_temperature_core.sv */
// ntc thermistor reading to temperature, extended steinhart-hart, fully pipelined
// 96 pipeline stages followed by the output queue
// throughput: one beat per cycle; every stage advances while the 2-entry output queue
// has a free slot, so a stalled result holds the input once both slots are full
// reset: rst_n async active low clears all stage valids and the output queue,
// divider_resistance returns to 10000 ohms
module thermistor_voltage_to_temperature_core
    import ntcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: divider_resistance in ohms
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // reading_code[15:0], reference_code[31:16]
    input  logic [3:0]  s_axis_tuser,   // channel[3:0]
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // temperature[14:0], status[16:15], zero fill
    output logic [3:0]  m_axis_tuser    // channel_out[3:0]
);

    logic [RES_W-1:0] div_res_reg;

    // config is always taken; the user is to write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_res_reg <= DIV_RES_RESET;
        end
        else if (cfg_valid)
        begin
            div_res_reg <= cfg_data;
        end
    end

    // global advance: every stage moves together while the queue can absorb a result
    logic en;
    assign s_axis_tready = en;

    logic [CODE_W-1:0] reading;
    logic [CODE_W-1:0] reference;
    ctl_t              in_ctl;

    assign reading   = s_axis_tdata[15:0];
    assign reference = s_axis_tdata[31:16];

    // zero reading or reading at or above reference is flagged and carried along
    assign in_ctl.valid   = s_axis_tvalid;
    assign in_ctl.channel = s_axis_tuser;
    assign in_ctl.bad     = (reading == '0) || (reading >= reference);

    // ratio and thermistor resistance (47 stages)
    ctl_t            ratio_ctl;
    logic [RT_W-1:0] rt_quot;
    logic            rt_ovf;

    ntcc_ratio u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctl    (in_ctl),
        .reading   (reading),
        .reference (reference),
        .div_res   (div_res_reg),
        .out_ctl   (ratio_ctl),
        .rt_quot   (rt_quot),
        .rt_ovf    (rt_ovf)
    );

    // ln(rt / 10000) through 20 squaring steps (25 stages)
    ctl_t               log_ctl;
    logic signed [25:0] ln_val;

    ntcc_log u_log (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (ratio_ctl),
        .rt_quot (rt_quot),
        .rt_ovf  (rt_ovf),
        .out_ctl (log_ctl),
        .ln_val  (ln_val)
    );

    // polynomial, reciprocal and limits (24 stages)
    ctl_t              poly_ctl;
    logic [TEMP_W-1:0] temperature;
    status_t           status;

    ntcc_poly u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_ctl      (log_ctl),
        .ln_val      (ln_val),
        .out_ctl     (poly_ctl),
        .temperature (temperature),
        .status      (status)
    );

    // output queue decouples the result side from the pipeline
    localparam int OQ_W = CHAN_W + 2 + TEMP_W;
    logic [OQ_W-1:0] oq_out;

    ntcc_outq #(
        .W (OQ_W)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && poly_ctl.valid),
        .push_data ({poly_ctl.channel, status, temperature}),
        .space     (en),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (oq_out)
    );

    assign m_axis_tuser = oq_out[OQ_W-1 -: CHAN_W];
    assign m_axis_tdata = {7'b0000000, oq_out[TEMP_W+1:0]};

endmodule
